// ----- hw/rtl/trlt_pkg.sv -----
// trlt_pkg: shared types, codes and defaults of the typed refcount lock table
// no dependencies
package trlt_pkg;

  localparam int TableEntriesDefault = 64;
  localparam int KeyBitsDefault      = 64;
  localparam logic [31:0] MaxAgeReset = 32'd3600;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_LOOKUP  = 3'd2,
    ACT_REF     = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_CLR_ALL = 3'd5,
    ACT_CLR_TYP = 3'd6,
    ACT_COUNT   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OTHER    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // classified command handed from front to back
  typedef struct packed {
    action_t     action;
    logic [63:0] key;
    logic        ltype;
    logic        add_ref;
    logic [15:0] elapsed;
    logic        keyed;   // insert, release, lookup or reference
    logic        all;     // count over every type
    logic        sweep;   // tick or clear: writes slots during the scan
  } cmd_t;

endpackage

// ----- hw/rtl/trlt_front.sv -----
// trlt_front: accepts commands, classifies them and queues them for the back end
// depends on trlt_pkg
module trlt_front #(
  parameter int KEY_BITS = trlt_pkg::KeyBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [63:0]        object_key,
  input  logic               lock_type,
  input  logic               add_reference,
  input  logic [15:0]        elapsed_seconds,
  output logic               cmd_valid,
  output trlt_pkg::cmd_t     cmd,
  input  logic               cmd_take
);
  import trlt_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  cmd_t               queue [QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   fill;
  cmd_t               incoming;
  logic               push;
  logic               pop;

  // classify
  always_comb begin
    incoming.action  = action_t'(action);
    incoming.key     = object_key & ({64{1'b1}} >> (64 - KEY_BITS));
    incoming.ltype   = lock_type;
    incoming.add_ref = add_reference;
    incoming.elapsed = elapsed_seconds;
    incoming.keyed   = (action <= 3'(ACT_REF));
    incoming.all     = (action_t'(action) == ACT_CLR_ALL) || (action_t'(action) == ACT_COUNT);
    incoming.sweep   = (action_t'(action) == ACT_TICK) || (action_t'(action) == ACT_CLR_ALL) ||
                       (action_t'(action) == ACT_CLR_TYP);
  end

  assign busy      = (fill == (PtrBits+1)'(QueueDepth));
  assign push      = start && !busy;
  assign pop       = cmd_take && (fill != '0);
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    busy |-> !push) else $error("queue push while full");
  ap_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> !pop) else $error("queue pop while empty");
  ap_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1)) else $error("fill count slip");

endmodule

// ----- hw/rtl/trlt_back.sv -----
// trlt_back: scans the slot table for one queued command and returns its result
// depends on trlt_pkg
module trlt_back #(
  parameter int TABLE_ENTRIES = trlt_pkg::TableEntriesDefault,
  parameter int KEY_BITS      = trlt_pkg::KeyBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  trlt_pkg::cmd_t     cmd,
  output logic               cmd_take,
  input  logic [31:0]        max_lock_age,
  output logic               done,
  output logic [2:0]         status,
  output logic               present,
  output logic [15:0]        references,
  output logic [6:0]         type_count,
  output logic [6:0]         released_count
);
  import trlt_pkg::*;

  localparam int IdxBits = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntBits = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_COUNT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                ltype;
    logic [15:0]         refs;
    logic [31:0]         age;
  } slot_t;

  // slot store: memory plus valid bits in flops
  slot_t                    mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  state_t             state;
  cmd_t               cur;
  logic [CntBits-1:0] idx;        // scan counter, reaches TABLE_ENTRIES
  logic               rd_ok;      // read data belongs to rd_idx
  logic [IdxBits-1:0] rd_idx;
  slot_t              rd_data;
  logic               hit;
  logic [IdxBits-1:0] hit_idx;
  logic               free_found;
  logic [IdxBits-1:0] free_idx;
  logic [CntBits-1:0] tally;
  logic [CntBits-1:0] freed;
  logic [2:0]         st;
  logic               pres;
  logic [15:0]        refs_out;

  // scan read side
  logic [IdxBits-1:0] scan_idx;
  assign scan_idx = idx[IdxBits-1:0];

  // per-slot sweep arithmetic
  logic        rd_valid;
  logic        match_key;
  logic        sel_sweep;
  logic [32:0] age_sum;
  logic [31:0] age_new;
  logic [15:0] refs_dec;
  logic        over;
  logic        sweep_free;
  logic        sweep_write;
  slot_t       sweep_data;

  always_comb begin
    rd_valid   = valid[rd_idx];
    match_key  = rd_valid && (rd_data.key == cur.key[KEY_BITS-1:0]);
    sel_sweep  = rd_valid && ((cur.action == ACT_CLR_ALL) || (rd_data.ltype == cur.ltype));
    age_sum    = {1'b0, rd_data.age} + 33'(cur.elapsed);
    age_new    = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    over       = age_new > max_lock_age;
    refs_dec   = (rd_data.refs != 16'd0) ? rd_data.refs - 16'd1 : 16'd0;
    sweep_data = rd_data;
    sweep_free = 1'b0;
    sweep_write = 1'b0;
    if (cur.action == ACT_TICK) begin
      sweep_write     = sel_sweep;
      sweep_data.age  = age_new;
      if (over) begin
        sweep_data.refs = refs_dec;
        sweep_free      = sel_sweep && (refs_dec == 16'd0);
      end
    end else begin
      sweep_free = sel_sweep;
    end
  end

  // apply step for keyed actions
  slot_t       ap_data;
  logic        ap_write;
  logic        ap_set;
  logic        ap_clr;
  logic [IdxBits-1:0] ap_idx;
  logic [2:0]  ap_st;
  logic        ap_pres;
  logic [15:0] ap_refs;
  logic        ap_freed;

  always_comb begin
    ap_data  = rd_data;
    ap_write = 1'b0;
    ap_set   = 1'b0;
    ap_clr   = 1'b0;
    ap_idx   = hit_idx;
    ap_st    = ST_OK;
    ap_pres  = hit;
    ap_refs  = hit ? rd_data.refs : 16'd0;
    ap_freed = 1'b0;
    case (cur.action)
      ACT_INSERT: begin
        if (hit) begin
          if (rd_data.ltype != cur.ltype) begin
            ap_st = ST_OTHER;
          end else begin
            if (cur.add_ref && rd_data.refs != 16'hFFFF) ap_data.refs = rd_data.refs + 16'd1;
            ap_write = 1'b1;
            ap_refs  = ap_data.refs;
          end
        end else if (!free_found) begin
          ap_st = ST_FULL;
        end else begin
          ap_idx        = free_idx;
          ap_data.key   = cur.key[KEY_BITS-1:0];
          ap_data.ltype = cur.ltype;
          ap_data.refs  = cur.add_ref ? 16'd1 : 16'd0;
          ap_data.age   = 32'd0;
          ap_write = 1'b1;
          ap_set   = 1'b1;
          ap_pres  = 1'b1;
          ap_refs  = ap_data.refs;
        end
      end
      ACT_RELEASE: begin
        if (!hit) begin
          ap_st = ST_NOTFOUND;
        end else if (rd_data.ltype != cur.ltype) begin
          ap_st = ST_MISMATCH;
        end else begin
          ap_data.refs = refs_dec;
          ap_write = 1'b1;
          ap_refs  = refs_dec;
          if (refs_dec == 16'd0) begin
            ap_clr   = 1'b1;
            ap_freed = 1'b1;
            ap_pres  = 1'b0;
          end
        end
      end
      ACT_LOOKUP: begin
        if (!hit) ap_st = ST_NOTFOUND;
      end
      ACT_REF: begin
        if (!hit) begin
          ap_st = ST_NOTFOUND;
        end else begin
          if (rd_data.refs != 16'hFFFF) ap_data.refs = rd_data.refs + 16'd1;
          ap_data.age = 32'd0;
          ap_write = 1'b1;
          ap_refs  = ap_data.refs;
        end
      end
      default: begin
        ap_pres = 1'b0;
        ap_refs = 16'd0;
      end
    endcase
  end

  // memory write and read ports
  logic               mem_we;
  logic [IdxBits-1:0] mem_wa;
  slot_t              mem_wd;
  logic [IdxBits-1:0] mem_ra;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx;
    mem_wd = sweep_data;
    mem_ra = scan_idx;
    if (state == S_SCAN && cur.sweep && rd_ok) begin
      mem_we = sweep_write;
    end else if (state == S_APPLY) begin
      mem_we = ap_write;
      mem_wa = ap_idx;
      mem_wd = ap_data;
    end
    if (state == S_SCAN && cur.keyed && (idx == CntBits'(TABLE_ENTRIES))) begin
      mem_ra = hit_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      done  <= 1'b0;
      rd_ok <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur        <= cmd;
            idx        <= '0;
            rd_ok      <= 1'b0;
            hit        <= 1'b0;
            hit_idx    <= '0;
            free_found <= 1'b0;
            free_idx   <= '0;
            freed      <= '0;
            tally      <= '0;
            state      <= (cmd.keyed || cmd.sweep) ? S_SCAN : S_COUNT;
          end
        end
        S_SCAN: begin
          // one slot read issued per cycle, result checked once its registered read data returns
          rd_idx <= scan_idx;
          rd_ok  <= (idx != CntBits'(TABLE_ENTRIES));
          if (idx != CntBits'(TABLE_ENTRIES)) idx <= idx + 1'b1;
          if (rd_ok) begin
            if (cur.keyed) begin
              if (match_key && !hit) begin
                hit     <= 1'b1;
                hit_idx <= rd_idx;
              end
              if (!rd_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= rd_idx;
              end
            end else if (sweep_free) begin
              valid[rd_idx] <= 1'b0;
              freed         <= freed + 1'b1;
            end
          end
          if (idx == CntBits'(TABLE_ENTRIES) && !rd_ok) begin
            // last slot handled; keyed commands wait for the hit read
            rd_ok <= 1'b0;
            idx   <= '0;
            state <= cur.keyed ? S_APPLY : S_COUNT;
          end
        end
        S_APPLY: begin
          if (ap_set) valid[ap_idx] <= 1'b1;
          if (ap_clr) valid[ap_idx] <= 1'b0;
          st       <= ap_st;
          pres     <= ap_pres;
          refs_out <= ap_refs;
          freed    <= CntBits'(ap_freed);
          idx      <= '0;
          state    <= S_COUNT;
        end
        S_COUNT: begin
          // same read pipeline as the scan, each slot tallied once its registered read data returns
          rd_idx <= scan_idx;
          rd_ok  <= (idx != CntBits'(TABLE_ENTRIES));
          if (idx != CntBits'(TABLE_ENTRIES)) idx <= idx + 1'b1;
          if (rd_ok && rd_valid && (cur.all || rd_data.ltype == cur.ltype))
            tally <= tally + 1'b1;
          if (idx == CntBits'(TABLE_ENTRIES) && !rd_ok) begin
            rd_ok <= 1'b0;
            idx   <= '0;
            state <= S_DONE;
          end
          if (!cur.keyed) begin
            st       <= ST_OK;
            pres     <= 1'b0;
            refs_out <= 16'd0;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status         = st;
  assign present        = pres;
  assign references     = refs_out;
  assign type_count     = 7'(tally);
  assign released_count = 7'(freed);

  ap_done_after: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE)) else $error("result without finishing");
  ap_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == S_IDLE)) else $error("command taken mid-run");
  ap_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !present) |-> (references == 16'd0)) else $error("refs for absent key");

endmodule

// ----- hw/rtl/typed_refcount_lock_table.sv -----
// typed_refcount_lock_table: top level of the typed refcount lock table
// depends on trlt_pkg, trlt_front, trlt_back
//
// channel  | handshake               | payload
// command  | start / busy            | action object_key lock_type add_reference elapsed_seconds
// config   | cfg_we                  | cfg_wdata (max_lock_age)
// result   | done strobe, one cycle  | status present references type_count released_count
//
// on an idle back end a keyed command goes from start to done through
// a scan of the slot memory through its single read port, an apply step, then a
// counting pass through the same port; tick and clear skip the apply step, and
// count runs only the counting pass
// a two-entry queue takes commands while the back end works; busy when it is full
// synchronous active-high reset clears valid bits, queue and sequencer
// results cannot be stalled by the receiver
module typed_refcount_lock_table #(
  parameter int TABLE_ENTRIES = trlt_pkg::TableEntriesDefault,
  parameter int KEY_BITS      = trlt_pkg::KeyBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [63:0] object_key,
  input  logic        lock_type,
  input  logic        add_reference,
  input  logic [15:0] elapsed_seconds,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic [2:0]  status,
  output logic        present,
  output logic [15:0] references,
  output logic [6:0]  type_count,
  output logic [6:0]  released_count
);
  import trlt_pkg::*;

  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_take;
  logic [31:0] max_lock_age;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) max_lock_age <= MaxAgeReset;
    else if (cfg_we) max_lock_age <= cfg_wdata;
  end

  trlt_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk, .rst, .start, .busy, .action, .object_key, .lock_type,
    .add_reference, .elapsed_seconds, .cmd_valid, .cmd, .cmd_take
  );

  trlt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .max_lock_age, .done, .status,
    .present, .references, .type_count, .released_count
  );

endmodule

// ----- verif/typed_refcount_lock_table_test.sv -----
// typed_refcount_lock_table_test: self-checking testbench for the typed refcount lock table
// depends on trlt_pkg and typed_refcount_lock_table; a scoreboard class predicts every result
module typed_refcount_lock_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import trlt_pkg::*;

  localparam int Slots      = 64;
  localparam int CycleLimit = 2000000;
  localparam int Latency    = 2 * Slots + 20;

  typedef struct {
    status_t     status;
    logic        present;
    logic [15:0] references;
    logic [6:0]  type_count;
    logic [6:0]  released_count;
  } lock_result_t;

  // lock table predictor with its queue of pending results
  class lock_table_scoreboard;
    bit           held[Slots];
    logic [63:0]  key_of[Slots];
    logic         type_of[Slots];
    logic [15:0]  refs_of[Slots];
    logic [31:0]  age_of[Slots];
    logic [31:0]  age_limit;
    lock_result_t pending[$];
    int           mismatches;

    function new();
      foreach (held[i]) held[i] = 0;
      age_limit  = MaxAgeReset;
      mismatches = 0;
    endfunction

    function int find_key(logic [63:0] k);
      for (int i = 0; i < Slots; i++)
        if (held[i] && key_of[i] == k) return i;
      return -1;
    endfunction

    // one release on a held slot, returns 1 when it frees the slot
    function bit drop_one(int i);
      if (refs_of[i] != 0) refs_of[i]--;
      if (refs_of[i] == 0) begin
        held[i] = 0;
        return 1;
      end
      return 0;
    endfunction

    // accepted command transfer: work out its result
    function void note_command(action_t act, logic [63:0] k, logic lt, logic add,
                               logic [15:0] secs);
      lock_result_t r;
      int s;
      int freed;
      int n;
      logic [32:0] sum;
      r.status = ST_OK;
      s = -1;
      freed = 0;
      n = 0;
      case (act)
        ACT_INSERT: begin
          s = find_key(k);
          if (s >= 0 && type_of[s] != lt) r.status = ST_OTHER;
          else begin
            if (s < 0) begin
              for (int i = 0; i < Slots; i++)
                if (!held[i]) begin
                  s = i;
                  break;
                end
              if (s >= 0) begin
                held[s] = 1;
                key_of[s] = k;
                type_of[s] = lt;
                refs_of[s] = 0;
                age_of[s] = 0;
              end
            end
            if (s < 0) r.status = ST_FULL;
            else if (add && refs_of[s] != 16'hFFFF) refs_of[s]++;
          end
        end
        ACT_RELEASE: begin
          s = find_key(k);
          if (s < 0) r.status = ST_NOTFOUND;
          else if (type_of[s] != lt) r.status = ST_MISMATCH;
          else if (drop_one(s)) freed = 1;
        end
        ACT_LOOKUP: begin
          s = find_key(k);
          if (s < 0) r.status = ST_NOTFOUND;
        end
        ACT_REF: begin
          s = find_key(k);
          if (s < 0) r.status = ST_NOTFOUND;
          else begin
            if (refs_of[s] != 16'hFFFF) refs_of[s]++;
            age_of[s] = 0;
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < Slots; i++) begin
            if (!held[i] || type_of[i] != lt) continue;
            sum = {1'b0, age_of[i]} + secs;
            age_of[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (age_of[i] > age_limit && drop_one(i)) freed++;
          end
        end
        ACT_CLR_ALL, ACT_CLR_TYP: begin
          for (int i = 0; i < Slots; i++)
            if (held[i] && (act == ACT_CLR_ALL || type_of[i] == lt)) begin
              held[i] = 0;
              freed++;
            end
        end
        default: ;
      endcase
      for (int i = 0; i < Slots; i++)
        if (held[i] && (act == ACT_CLR_ALL || act == ACT_COUNT || type_of[i] == lt)) n++;
      r.present = (act <= ACT_REF) && s >= 0 && held[s];
      r.references = r.present ? refs_of[s] : 16'd0;
      r.type_count = n[6:0];
      r.released_count = freed[6:0];
      pending.push_back(r);
    endfunction

    function void report(string what, string exp_s, string got_s);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %s, got %s", what, exp_s, got_s);
    endfunction

    // result transfer against the oldest expectation
    function void check_result(lock_result_t got);
      lock_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", "none", $sformatf("status %0d", got.status));
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status)
        report("status", $sformatf("%0d", e.status), $sformatf("%0d", got.status));
      if (got.present !== e.present)
        report("present", $sformatf("%0d", e.present), $sformatf("%0d", got.present));
      if (got.references !== e.references)
        report("references", $sformatf("%0d", e.references), $sformatf("%0d", got.references));
      if (got.type_count !== e.type_count)
        report("type_count", $sformatf("%0d", e.type_count), $sformatf("%0d", got.type_count));
      if (got.released_count !== e.released_count)
        report("released_count", $sformatf("%0d", e.released_count),
               $sformatf("%0d", got.released_count));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [63:0] object_key = '0;
  logic        lock_type = 0;
  logic        add_reference = 0;
  logic [15:0] elapsed_seconds = '0;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic        done;
  logic [2:0]  status;
  logic        present;
  logic [15:0] references;
  logic [6:0]  type_count;
  logic [6:0]  released_count;

  lock_table_scoreboard lock_sb = new();
  int          taken = 0;
  int          cycles = 0;
  bit          quiet = 0;
  logic [63:0] key_pool[$];

  typed_refcount_lock_table #(.TABLE_ENTRIES(Slots), .KEY_BITS(64)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .object_key(object_key), .lock_type(lock_type), .add_reference(add_reference),
    .elapsed_seconds(elapsed_seconds), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .status(status), .present(present), .references(references),
    .type_count(type_count), .released_count(released_count)
  );

  always #5 clk = ~clk;

  // monitor: command and result transfers at the rising edge
  always @(posedge clk) begin
    lock_result_t got;
    if (!rst && start && !busy) begin
      lock_sb.note_command(action_t'(action), object_key, lock_type, add_reference,
                           elapsed_seconds);
      taken++;
    end
    if (!rst && done) begin
      got.status = status_t'(status);
      got.present = present;
      got.references = references;
      got.type_count = type_count;
      got.released_count = released_count;
      lock_sb.check_result(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // drive one command, holding start until the transfer happens
  task automatic send(action_t act, logic [63:0] k, logic lt, logic add, logic [15:0] secs);
    int target;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    action = act;
    object_key = k;
    lock_type = lt;
    add_reference = add;
    elapsed_seconds = secs;
    start = 1;
    target = taken + 1;
    wait (taken == target);
    @(negedge clk);
  endtask

  // register write once everything has drained
  task automatic set_age_limit(logic [31:0] v);
    start = 0;
    wait (lock_sb.pending.size() == 0);
    repeat (Latency) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    lock_sb.age_limit = v;
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_secs();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'($urandom);
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic random_command();
    int w;
    action_t act;
    w = $urandom_range(0, 99);
    if (w < 35) act = ACT_INSERT;
    else if (w < 55) act = ACT_RELEASE;
    else if (w < 65) act = ACT_LOOKUP;
    else if (w < 75) act = ACT_REF;
    else if (w < 85) act = ACT_TICK;
    else if (w < 87) act = ACT_CLR_ALL;
    else if (w < 90) act = ACT_CLR_TYP;
    else act = ACT_COUNT;
    send(act, pick_key(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_secs());
  endtask

  initial begin
    logic [31:0] limits[6];
    int pool_sizes[3];
    limits = '{32'd0, 32'hFFFF_FFFF, 32'd20, 32'd3600, 32'd5, 32'd0};
    pool_sizes = '{4, 16, 72};
    repeat (4) @(negedge clk);
    rst = 0;

    // directed: joins, refusals, absent keys, release at zero, tick, clears
    send(ACT_INSERT, 64'd0, 0, 1, 0);
    send(ACT_INSERT, '1, 1, 0, 0);
    send(ACT_INSERT, 64'd0, 1, 1, 0);
    send(ACT_INSERT, 64'd0, 0, 1, 0);
    send(ACT_LOOKUP, 64'h5555_AAAA_5555_AAAA, 0, 0, 0);
    send(ACT_REF, 64'hAAAA_5555_AAAA_5555, 1, 0, 0);
    send(ACT_REF, '1, 0, 0, 0);
    send(ACT_RELEASE, 64'd0, 1, 0, 0);
    send(ACT_RELEASE, 64'h1234, 0, 0, 0);
    send(ACT_COUNT, 64'd0, 1, 0, 0);
    send(ACT_TICK, 64'd0, 0, 0, 16'hFFFF);
    send(ACT_LOOKUP, 64'd0, 0, 0, 0);
    send(ACT_INSERT, 64'h8000_0000_0000_0001, 1, 0, 0);
    send(ACT_RELEASE, 64'h8000_0000_0000_0001, 1, 0, 0);
    send(ACT_TICK, 64'd0, 1, 0, 16'd0);
    send(ACT_CLR_TYP, 64'd0, 0, 0, 0);
    send(ACT_LOOKUP, '1, 1, 0, 0);
    send(ACT_CLR_ALL, 64'd0, 0, 0, 0);
    send(ACT_COUNT, 64'd0, 0, 0, 0);

    // random phases, each with its own key pool and age limit
    for (int ph = 0; ph < 9; ph++) begin
      set_age_limit(ph < 6 ? limits[ph] : $urandom);
      key_pool.delete();
      repeat (pool_sizes[ph % 3]) key_pool.push_back({$urandom, $urandom});
      if (ph == 8) quiet = 1;
      repeat (148) random_command();
    end

    start = 0;
    wait (lock_sb.pending.size() == 0);
    repeat (Latency) @(posedge clk);
    if (lock_sb.mismatches == 0 && lock_sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
